FILE: rtl/core/cdq_pkg.sv
// Shared types and constants for the circular deque core.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    // Default number of entries held by the deque.
    localparam int unsigned DEF_DEPTH = 128;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned OCC_W  = 8;

    typedef enum logic [1:0] {
        REQ_INS_FRONT = 2'd0,
        REQ_INS_REAR  = 2'd1,
        REQ_REM_FRONT = 2'd2,
        REQ_REM_REAR  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One-hot operation broadcast to every cell; all zero means hold.
    typedef struct packed {
        logic ins_front;
        logic ins_rear;
        logic rem_front;
        logic rem_rear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: rtl/core/circular_deque_core.sv
// Top level of the circular deque: request and result streams around a row of cells.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A request beat on the slave stream carries the request kind in s_axis_tuser
// (insert front, insert rear, remove front, remove rear) and the word to insert
// in s_axis_tdata. Every request yields exactly one result beat on the master
// stream: the status in m_axis_tuser (done, refused because full, refused
// because empty), the removed word and the occupancy after the request.
// The entries live in a row of DEPTH cells kept packed from the front: cell 0
// holds the front entry. An insert at the front shifts the whole row one cell
// toward the rear, a removal at the front shifts it one cell toward the front,
// and rear operations touch only the cell at the boundary of the valid run.
// The result beat comes in the cycle after its request beat is taken, and one
// request is taken every cycle while the receiver does not stall; this rests on
// the update of the cell row and the select of the rear word across all cells.
// The result waits in an output register; while the receiver stalls, a new
// request is taken only in the cycle in which that result is taken.
// Reset leaves the deque empty and the output register without a result.

module circular_deque_core #(
    parameter int unsigned DEPTH = cdq_pkg::DEF_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] data_in
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] removed_value, [39:32] occupancy
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic                        w_valid     [DEPTH];
    logic [cdq_pkg::WORD_W-1:0]  w_data      [DEPTH];
    logic [cdq_pkg::WORD_W-1:0]  w_tail_data [DEPTH];

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic                        r_out_valid;
    cdq_pkg::t_status            r_status;
    cdq_pkg::t_status            n_status;
    logic [cdq_pkg::WORD_W-1:0]  r_removed;
    logic [cdq_pkg::WORD_W-1:0]  n_removed;

    logic                        w_accept;
    logic                        w_full;
    logic                        w_empty;
    cdq_pkg::t_req               w_req;
    cdq_pkg::t_cell_ctrl         w_ctrl;
    logic [cdq_pkg::WORD_W-1:0]  w_rear_word;

    assign s_axis_tready = ~r_out_valid | m_axis_tready;
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_req         = cdq_pkg::t_req'(s_axis_tuser);
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_empty       = (r_count == '0);

    // Decode the request against the fill level; a refused request holds the row.
    always_comb begin
        w_ctrl    = '0;
        n_status  = cdq_pkg::ST_DONE;
        n_removed = '0;
        n_count   = r_count;
        unique case (w_req)
            cdq_pkg::REQ_INS_FRONT, cdq_pkg::REQ_INS_REAR: begin
                if (w_full) begin
                    n_status = cdq_pkg::ST_FULL;
                end else begin
                    w_ctrl.ins_front = (w_req == cdq_pkg::REQ_INS_FRONT);
                    w_ctrl.ins_rear  = (w_req == cdq_pkg::REQ_INS_REAR);
                    n_count          = r_count + CNT_W'(1);
                end
            end
            cdq_pkg::REQ_REM_FRONT: begin
                if (w_empty) begin
                    n_status = cdq_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.rem_front = 1'b1;
                    n_removed        = w_data[0];
                    n_count          = r_count - CNT_W'(1);
                end
            end
            cdq_pkg::REQ_REM_REAR: begin
                if (w_empty) begin
                    n_status = cdq_pkg::ST_EMPTY;
                end else begin
                    w_ctrl.rem_rear = 1'b1;
                    n_removed       = w_rear_word;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = cdq_pkg::ST_DONE;
            end
        endcase
        if (!w_accept) begin
            w_ctrl = '0;
        end
    end

    // Only the rear cell passes its word, so an OR across the row selects it.
    always_comb begin
        w_rear_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear_word = w_rear_word | w_tail_data[i];
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                       w_prev_valid;
        logic [cdq_pkg::WORD_W-1:0] w_prev_data;
        logic                       w_next_valid;
        logic [cdq_pkg::WORD_W-1:0] w_next_data;

        // The front cell takes the new word when the row shifts rearward.
        if (g == 0) begin : g_first
            assign w_prev_valid = 1'b1;
            assign w_prev_data  = s_axis_tdata;
        end else begin : g_inner_prev
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_data  = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_data  = '0;
        end else begin : g_inner_next
            assign w_next_valid = w_valid[g+1];
            assign w_next_data  = w_data[g+1];
        end

        cdq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_word       (s_axis_tdata),
            .i_prev_valid (w_prev_valid),
            .i_prev_data  (w_prev_data),
            .i_next_valid (w_next_valid),
            .i_next_data  (w_next_data),
            .o_valid      (w_valid[g]),
            .o_data       (w_data[g]),
            .o_tail_data  (w_tail_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {cdq_pkg::OCC_W'(r_count), r_removed};

    // The fill count and the valid run of the cell row must agree at both ends.
    a_front_matches_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == !w_valid[0])
        else $error("front cell valid disagrees with fill count");

    a_rear_matches_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full == w_valid[DEPTH-1])
        else $error("last cell valid disagrees with full state");

    a_empty_refusal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_empty && (w_req == cdq_pkg::REQ_REM_FRONT ||
                                 w_req == cdq_pkg::REQ_REM_REAR))
        |=> (m_axis_tvalid && m_axis_tuser == cdq_pkg::ST_EMPTY &&
             m_axis_tdata[cdq_pkg::WORD_W-1:0] == '0))
        else $error("removal from empty deque not refused");

    a_full_occupancy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == cdq_pkg::ST_FULL) |-> w_full)
        else $error("full refusal reported while not full");

endmodule

`default_nettype wire

FILE: rtl/core/cdq_cell.sv
// One storage cell of the deque row: a word, its valid bit and the shift logic.
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cdq_pkg::t_cell_ctrl           i_ctrl,
    input  wire logic [cdq_pkg::WORD_W-1:0]    i_word,
    input  wire logic                          i_prev_valid,
    input  wire logic [cdq_pkg::WORD_W-1:0]    i_prev_data,
    input  wire logic                          i_next_valid,
    input  wire logic [cdq_pkg::WORD_W-1:0]    i_next_data,
    output logic                               o_valid,
    output logic [cdq_pkg::WORD_W-1:0]         o_data,
    output logic [cdq_pkg::WORD_W-1:0]         o_tail_data
);

    logic                       r_valid;
    logic                       n_valid;
    logic [cdq_pkg::WORD_W-1:0] r_data;
    logic [cdq_pkg::WORD_W-1:0] n_data;
    logic                       w_is_tail;
    logic                       w_is_slot;

    // The cell holding the rear entry, and the first free cell after it.
    assign w_is_tail = r_valid & ~i_next_valid;
    assign w_is_slot = ~r_valid & i_prev_valid;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.ins_front) begin
            n_valid = i_prev_valid;
            n_data  = i_prev_data;
        end else if (i_ctrl.ins_rear) begin
            if (w_is_slot) begin
                n_valid = 1'b1;
                n_data  = i_word;
            end
        end else if (i_ctrl.rem_front) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_ctrl.rem_rear) begin
            if (w_is_tail) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid     = r_valid;
    assign o_data      = r_data;
    assign o_tail_data = r_data & {cdq_pkg::WORD_W{w_is_tail}};

endmodule

`default_nettype wire
